// File: sv/indexed_removal_stack_macros.svh
// Assertion helpers shared by the stack RTL.
`ifndef INDEXED_REMOVAL_STACK_MACROS_SVH
`define INDEXED_REMOVAL_STACK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("indexed_removal_stack: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("indexed_removal_stack: next-cycle check failed");

`endif

// File: sv/irs_pkg.sv
package irs_pkg;

  localparam int unsigned IDX_BITS   = 5;
  localparam int unsigned VAL_BITS   = 32;
  localparam int unsigned COUNT_BITS = 6;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TOP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [VAL_BITS-1:0] value;
    logic [IDX_BITS-1:0] index;
  } in_t;

  typedef struct packed {
    logic [VAL_BITS-1:0]   data;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
  } out_t;

endpackage

// File: sv/irs_mem.sv
module irs_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/indexed_removal_stack.sv
// Bounded stack of DEPTH words held in a one-write, one-read memory, with push, read-top
// and remove-at-index commands; each command gives exactly one result transaction.
// A command is taken only while the sequencer is idle. Push goes EXEC then DONE, read-top
// EXEC, TOP_WORD and DONE, and remove EXEC, RM_WORD, one SHIFT step per entry above the index
// (count - index - 1 of them) and DONE: closing the gap moves one entry per cycle through the
// memory's single read and write ports, driven by the ptr+1 and ptr+2 incrementers and
// their compares. Out-of-range and empty cases go EXEC then DONE. A finished result sits
// in an output register, so the next command can be accepted while it waits to be taken.
`include "indexed_removal_stack_macros.svh"

module indexed_removal_stack #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  irs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output irs_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > irs_pkg::IDX_BITS) ? CW : irs_pkg::IDX_BITS;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_TOP_WORD = 6'b000100,
    S_RM_WORD  = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [1:0]           st_q, st_d;
  logic                 out_valid_q, out_valid_d;
  irs_pkg::out_t        out_q, out_d;

  logic [1:0]           cmd_q;
  logic [WORD_BITS-1:0] val_q;
  logic [IW-1:0]        idx_q;

  logic                 accept;
  logic [63:0]          val_wide;
  logic [63:0]          word_wide;
  logic [31:0]          cnt_wide;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        ptr_p1;
  logic [CW-1:0]        ptr_p2;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  irs_mem #(
    .DEPTH(DEPTH),
    .WIDTH(WORD_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign val_wide  = 64'(in_data_i.value);
  assign word_wide = 64'(word_q);
  assign cnt_wide  = 32'(cnt_q);
  assign cnt_m1    = cnt_q - CW'(1);
  assign ptr_p1    = ptr_q + CW'(1);
  assign ptr_p2    = ptr_q + CW'(2);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    word_d      = word_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_p1[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        word_d  = '0;
        st_d    = irs_pkg::ST_OK;
        state_d = S_DONE;
        priority if (cmd_q == irs_pkg::CMD_PUSH) begin
          if (cnt_q < CW'(DEPTH)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end else begin
            st_d = irs_pkg::ST_FULL;
          end
        end else if (cmd_q == irs_pkg::CMD_REMOVE) begin
          if (idx_q >= IW'(cnt_q)) begin
            st_d = irs_pkg::ST_RANGE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q[AW-1:0];
            ptr_d     = idx_q[CW-1:0];
            state_d   = S_RM_WORD;
          end
        end else begin
          // Read-top; the unused command code behaves the same way.
          if (cnt_q == '0) begin
            st_d = irs_pkg::ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cnt_m1[AW-1:0];
            state_d   = S_TOP_WORD;
          end
        end
      end
      S_TOP_WORD: begin
        word_d  = mem_rdata;
        state_d = S_DONE;
      end
      S_RM_WORD: begin
        word_d = mem_rdata;
        if (ptr_p1 < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_p1[AW-1:0];
          state_d   = S_SHIFT;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        // Write back the entry read last cycle one place lower, and fetch the next one.
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_d     = ptr_p1;
        if (ptr_p2 < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_p2[AW-1:0];
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.data     = word_wide[irs_pkg::VAL_BITS-1:0];
          out_d.status   = st_q;
          out_d.count    = cnt_wide[irs_pkg::COUNT_BITS-1:0];
          out_d.is_empty = (cnt_q == '0);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    word_q <= word_d;
    st_q   <= st_d;
    out_q  <= out_d;
    if (accept) begin
      cmd_q <= in_data_i.cmd;
      val_q <= val_wide[WORD_BITS-1:0];
      idx_q <= IW'(in_data_i.index);
    end
  end

  `IRS_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH))
  `IRS_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, accept, state_q == S_EXEC)
  `IRS_ASSERT_NEXT(a_idle_cnt_hold, clk_i, rst_ni, state_q == S_IDLE, $stable(cnt_q))
  `IRS_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE))

endmodule
